FILE: hdl/blm_pkg.sv
// blm_pkg: shared types, constants and register map of the battery level monitor
// no dependencies; imported by every module of the block
`default_nettype none

package blm_pkg;

    localparam int WINDOW_DEF = 10;
    localparam int SAMPLE_W   = 12;
    localparam int TOTAL_W    = 16;
    localparam int MV_W       = 16;
    localparam int CHARGE_W   = 10;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [CHARGE_W-1:0] CHARGE_MAX = 10'd1000;
    localparam logic [32:0]         ROUND_HALF = 33'd32768;

    localparam logic [15:0] MV_SCALE_RST    = 16'd24021;
    localparam logic [15:0] EMPTY_MV_RST    = 16'd10500;
    localparam logic [15:0] CHARGE_GAIN_RST = 16'd19859;
    localparam logic [15:0] LOW_MV_RST      = 16'd11000;

    typedef enum logic [1:0] {
        REG_MV_SCALE    = 2'd0,
        REG_EMPTY_MV    = 2'd1,
        REG_CHARGE_GAIN = 2'd2,
        REG_LOW_MV      = 2'd3
    } blm_reg_idx_t;

    typedef struct packed {
        logic [15:0] mv_scale_q16;
        logic [15:0] empty_mv;
        logic [15:0] charge_gain_q16;
        logic [15:0] low_mv;
    } blm_cfg_t;

    typedef struct packed {
        logic load_sample;
        logic fill_wr;
        logic read_old;
        logic update;
        logic mul_mv;
        logic mul_chg;
        logic load_out;
    } blm_cmd_t;

    typedef struct packed {
        logic fill_last;
    } blm_sts_t;

endpackage

`default_nettype wire

FILE: hdl/blm_regs.sv
// blm_regs: apb configuration registers of the battery level monitor
// depends on blm_pkg
`default_nettype none

module blm_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [blm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [blm_pkg::DATA_W-1:0]  pwdata,
    output logic      [blm_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output blm_pkg::blm_cfg_t                cfg
);
    import blm_pkg::*;

    blm_cfg_t     cfg_reg;
    blm_cfg_t     cfg_next;
    blm_reg_idx_t idx;
    logic         wr_en;

    assign idx   = blm_reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MV_SCALE:    cfg_next.mv_scale_q16    = pwdata[15:0];
                REG_EMPTY_MV:    cfg_next.empty_mv        = pwdata[15:0];
                REG_CHARGE_GAIN: cfg_next.charge_gain_q16 = pwdata[15:0];
                REG_LOW_MV:      cfg_next.low_mv          = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mv_scale_q16    <= MV_SCALE_RST;
            cfg_reg.empty_mv        <= EMPTY_MV_RST;
            cfg_reg.charge_gain_q16 <= CHARGE_GAIN_RST;
            cfg_reg.low_mv          <= LOW_MV_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_MV_SCALE:    prdata = {16'd0, cfg_reg.mv_scale_q16};
            REG_EMPTY_MV:    prdata = {16'd0, cfg_reg.empty_mv};
            REG_CHARGE_GAIN: prdata = {16'd0, cfg_reg.charge_gain_q16};
            REG_LOW_MV:      prdata = {16'd0, cfg_reg.low_mv};
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

FILE: hdl/blm_ctrl.sv
// blm_ctrl: sequencing state machine and output valid of the battery level monitor
// depends on blm_pkg; drives blm_dp through command and status structs
`default_nettype none

module blm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output blm_pkg::blm_cmd_t      cmd,
    input  wire blm_pkg::blm_sts_t sts
);
    import blm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FILL   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_UPDATE = 7'b0001000,
        ST_MV     = 7'b0010000,
        ST_CHG    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } blm_state_t;

    blm_state_t state_reg;
    blm_state_t state_next;
    logic       filled_reg;
    logic       filled_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        filled_next = filled_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = filled_reg ? ST_READ : ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (sts.fill_last)
                begin
                    filled_next = 1'b1;
                    state_next  = ST_MV;
                end
            end
            ST_READ:
            begin
                cmd.read_old = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_MV;
            end
            ST_MV:
            begin
                cmd.mul_mv = 1'b1;
                state_next = ST_CHG;
            end
            ST_CHG:
            begin
                cmd.mul_chg = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/blm_dp.sv
// blm_dp: sample ring, running total, q16 scaling and output registers
// depends on blm_pkg; steered by blm_ctrl
`default_nettype none

module blm_dp #(
    parameter int WINDOW = blm_pkg::WINDOW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire blm_pkg::blm_cmd_t             cmd,
    output blm_pkg::blm_sts_t                  sts,
    input  wire blm_pkg::blm_cfg_t             cfg,
    input  wire logic [blm_pkg::SAMPLE_W-1:0]  adc_sample,
    output logic      [blm_pkg::TOTAL_W-1:0]   window_total,
    output logic      [blm_pkg::MV_W-1:0]      battery_mv,
    output logic      [blm_pkg::CHARGE_W-1:0]  charge_tenths,
    output logic                               low_battery
);
    import blm_pkg::*;

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(WINDOW - 1);

    logic [SAMPLE_W-1:0] ring [WINDOW];

    logic [PW-1:0]       pos_reg;
    logic [PW-1:0]       pos_next;
    logic [PW-1:0]       fill_idx_reg;
    logic [PW-1:0]       fill_idx_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] old_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [MV_W-1:0]     mv_reg;
    logic [CHARGE_W-1:0] charge_reg;
    logic                low_reg;
    logic [TOTAL_W-1:0]  win_total_reg;
    logic [MV_W-1:0]     win_mv_reg;
    logic [CHARGE_W-1:0] win_charge_reg;
    logic                win_low_reg;

    logic [TOTAL_W-1:0]  fill_total;
    logic [TOTAL_W-1:0]  upd_total;
    logic [31:0]         mv_prod;
    logic [32:0]         mv_round;
    logic [MV_W-1:0]     mv_sat;
    logic [MV_W-1:0]     mv_diff;
    logic [31:0]         chg_prod;
    logic [32:0]         chg_round;
    logic [16:0]         chg_raw;
    logic [CHARGE_W-1:0] chg_val;

    assign fill_total = TOTAL_W'({4'd0, sample_reg} * 16'(WINDOW));
    assign upd_total  = total_reg - TOTAL_W'(old_reg) + TOTAL_W'(sample_reg);

    assign mv_prod  = 32'(total_reg) * 32'(cfg.mv_scale_q16);
    assign mv_round = {1'b0, mv_prod} + ROUND_HALF;
    assign mv_sat   = mv_round[32] ? 16'hFFFF : mv_round[31:16];

    assign mv_diff   = mv_reg - cfg.empty_mv;
    assign chg_prod  = 32'(mv_diff) * 32'(cfg.charge_gain_q16);
    assign chg_round = {1'b0, chg_prod} + ROUND_HALF;
    assign chg_raw   = chg_round[32:16];

    always_comb
    begin
        if (mv_reg <= cfg.empty_mv)
            chg_val = '0;
        else if (chg_raw > 17'(CHARGE_MAX))
            chg_val = CHARGE_MAX;
        else
            chg_val = chg_raw[CHARGE_W-1:0];
    end

    assign fill_idx_next = (fill_idx_reg == LAST_POS) ? '0 : fill_idx_reg + 1'b1;
    assign pos_next      = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign sts.fill_last = (fill_idx_reg == LAST_POS);

    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
            ring[fill_idx_reg] <= sample_reg;
        else if (cmd.update)
            ring[pos_reg] <= sample_reg;
        if (cmd.read_old)
            old_reg <= ring[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            fill_idx_reg <= '0;
            total_reg    <= '0;
        end
        else
        begin
            if (cmd.fill_wr)
            begin
                fill_idx_reg <= fill_idx_next;
                total_reg    <= fill_total;
            end
            if (cmd.update)
            begin
                pos_reg   <= pos_next;
                total_reg <= upd_total;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
            sample_reg <= adc_sample;
        if (cmd.mul_mv)
            mv_reg <= mv_sat;
        if (cmd.mul_chg)
        begin
            charge_reg <= chg_val;
            low_reg    <= (mv_reg < cfg.low_mv);
        end
        if (cmd.load_out)
        begin
            win_total_reg  <= total_reg;
            win_mv_reg     <= mv_reg;
            win_charge_reg <= charge_reg;
            win_low_reg    <= low_reg;
        end
    end

    assign window_total  = win_total_reg;
    assign battery_mv    = win_mv_reg;
    assign charge_tenths = win_charge_reg;
    assign low_battery   = win_low_reg;

endmodule

`default_nettype wire

FILE: hdl/battery_level_monitor_core.sv
// battery_level_monitor_core: top level of the moving-average battery gauge
// depends on blm_pkg, blm_regs, blm_ctrl, blm_dp
//
//   channel   handshake                 payload
//   input     in_valid / in_stall       adc_sample
//   output    out_valid / out_stall     window_total, battery_mv, charge_tenths, low_battery
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// first transaction after reset: fill all WINDOW ring slots, two q16 multiplies, output load
// later transactions: ring read, total update, two q16 multiplies, output load
// the multiply chain and the single ring port make these steps run in sequence
// a finished result waits in the output register; the next transaction is taken meanwhile
// out_stall held high holds the output register and parks the next result in the datapath
// rst_n clears control state; the ring is written by the first transaction before any read
`default_nettype none

module battery_level_monitor_core #(
    parameter int WINDOW = blm_pkg::WINDOW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [blm_pkg::SAMPLE_W-1:0]  adc_sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [blm_pkg::TOTAL_W-1:0]   window_total,
    output logic      [blm_pkg::MV_W-1:0]      battery_mv,
    output logic      [blm_pkg::CHARGE_W-1:0]  charge_tenths,
    output logic                               low_battery,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [blm_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [blm_pkg::DATA_W-1:0]    pwdata,
    output logic      [blm_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);
    import blm_pkg::*;

    blm_cfg_t cfg;
    blm_cmd_t cmd;
    blm_sts_t sts;

    blm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    blm_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg           (cfg),
        .adc_sample    (adc_sample),
        .window_total  (window_total),
        .battery_mv    (battery_mv),
        .charge_tenths (charge_tenths),
        .low_battery   (low_battery)
    );

endmodule

`default_nettype wire

FILE: hdl/blm_checker.sv
// blm_checker: port-level assertions for the battery level monitor
// depends on blm_pkg; bound to battery_level_monitor_core
`default_nettype none

module blm_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [blm_pkg::TOTAL_W-1:0]   window_total,
    input wire logic [blm_pkg::MV_W-1:0]      battery_mv,
    input wire logic [blm_pkg::CHARGE_W-1:0]  charge_tenths
);
    import blm_pkg::*;

    a_charge_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (charge_tenths <= CHARGE_MAX))
        else $error("charge out of range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled transaction dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(window_total) && $stable(battery_mv)))
        else $error("stalled payload changed");

endmodule

bind battery_level_monitor_core blm_checker u_blm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .window_total  (window_total),
    .battery_mv    (battery_mv),
    .charge_tenths (charge_tenths)
);

`default_nettype wire
